/* hdl/drs_pkg.sv */
// Shared types and constants of the dive record segmenter.
`default_nettype none

package drs_pkg;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  // Result status codes; the scan outcome register uses the same codes.
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NO_MORE = 2'd1;
  localparam logic [1:0] ST_NO_END  = 2'd2;
  localparam logic [1:0] ST_RUNNING = 2'd0;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINGERPRINT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF      = 1'd1;
  localparam int unsigned CFG_DATA_W = 32;

  // Record format.
  localparam logic [7:0] START_MARK    = 8'hFF;
  localparam logic [7:0] TIME_MARK     = 8'hFE;
  localparam int unsigned MARK_GAP     = 6;
  localparam int unsigned HEADER_LEN   = 7;
  localparam int unsigned STAMP_OFS    = 2;
  localparam int unsigned STAMP_BYTES  = 4;
  localparam logic [7:0] SHALLOW_DEPTH = 8'd16;
  localparam logic [4:0] SHALLOW_RUN   = 5'd17;
  localparam logic [2:0] TEMP_PERIOD   = 3'd6;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] dive_start;
    logic [15:0] dive_length;
    logic [31:0] dive_time;
  } res_t;

endpackage

`default_nettype wire

/* hdl/drs_if.sv */
// Valid/ready channel interfaces for requests and results of the segmenter.
`default_nettype none

interface drs_req_if;
  logic         valid;
  logic         ready;
  drs_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drs_res_if;
  logic         valid;
  logic         ready;
  drs_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/dive_record_segmenter.sv */
// Dive record segmenter: image store, backward marker search and forward sample scan.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+--------------------------------------------
//  req      | in  | valid / ready    | req_type, data_byte, last
//  res      | out | valid / ready    | status, dive_start, dive_length, dive_time
//  cfg      | in  | cfg_we           | cfg_index, cfg_data (no read-back)
//
// One image byte per cycle can be streamed in with loads while no find is in progress.
// A find sets up the walk, then checks each candidate offset on the 0xFE byte and,
// if that passes, on the 0xFF byte, scans the samples of a candidate that passes
// both, reads the timestamp bytes and hands over the result; the single memory
// read port serialises these steps. Requests are taken only between finds; a finished
// result waits in the output register while loads go on. Synchronous reset clears the
// state, pointers, outcome, fingerprint time and out_valid and sets cutoff_enable.
`default_nettype none

module dive_record_segmenter #(
  parameter int unsigned MEM_DEPTH = 32768
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  drs_req_if.sink                               req,
  drs_res_if.source                             res,
  input  wire logic                             cfg_we,
  input  wire logic [drs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [drs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam int unsigned PW = $clog2(MEM_DEPTH + 1);
  localparam int unsigned OW = PW + 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SEARCH   = 7'b0000010,
    S_PROBE_HI = 7'b0000100,
    S_PROBE_LO = 7'b0001000,
    S_SCAN     = 7'b0010000,
    S_STAMP    = 7'b0100000,
    S_RESULT   = 7'b1000000
  } state_t;

  state_t state;

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] rd_addr;
  logic [OW-1:0] rd_sum;

  logic [PW-1:0] write_pointer;
  logic [PW-1:0] image_size;
  logic [PW-1:0] scan_position;
  logic [PW-1:0] scan_limit;
  logic          scan_started;
  logic [1:0]    scan_outcome;

  logic [31:0]   fingerprint_time;
  logic          cutoff_enable;

  logic [OW-1:0] offset;
  logic [2:0]    phase;
  logic [4:0]    shallow;
  logic          depth_pend;
  logic [2:0]    stamp_idx;
  logic [23:0]   stamp_lo;

  drs_pkg::res_t pend_res;
  drs_pkg::res_t out_data;
  logic          out_valid;

  logic          req_acc;
  logic          load_acc;
  logic          find_acc;
  logic          do_advance;
  logic          is_shallow;
  logic          scan_found;
  logic          scan_stop;
  logic [OW-1:0] limit_ext;
  logic [31:0]   stamp;
  logic [31:0]   cur32;
  logic [31:0]   len32;
  logic [PW-1:0] wp_inc;

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign load_acc  = req_acc && (req.data.req_type == drs_pkg::REQ_LOAD);
  assign find_acc  = req_acc && (req.data.req_type == drs_pkg::REQ_FIND);

  assign res.valid = out_valid;
  assign res.data  = out_data;

  // A candidate is dropped when either marker byte misses.
  assign do_advance = (state == S_SEARCH) ||
                      ((state == S_PROBE_HI) && (rdata != drs_pkg::TIME_MARK)) ||
                      ((state == S_PROBE_LO) && (rdata != drs_pkg::START_MARK));

  assign limit_ext  = {1'b0, scan_limit};
  assign is_shallow = (rdata < drs_pkg::SHALLOW_DEPTH);
  assign scan_found = depth_pend && is_shallow &&
                      (shallow == drs_pkg::SHALLOW_RUN - 5'd1);
  // The next sample, plus its temperature byte on a first-of-six sample, must fit.
  assign scan_stop  = (offset >= limit_ext) ||
                      ((phase == 3'd0) && ((offset + OW'(1)) >= limit_ext));

  assign stamp  = {rdata, stamp_lo};
  assign cur32  = 32'(scan_position);
  assign len32  = 32'(offset) - cur32;
  assign wp_inc = write_pointer + PW'(1);

  always_comb begin
    rd_sum = '0;
    if (do_advance) begin
      rd_sum = {1'b0, scan_position} + OW'(drs_pkg::MARK_GAP - 1);
    end else if (state == S_PROBE_HI) begin
      rd_sum = {1'b0, scan_position};
    end else if (state == S_SCAN) begin
      rd_sum = offset;
    end else if (state == S_STAMP) begin
      rd_sum = {1'b0, scan_position} + OW'(drs_pkg::STAMP_OFS) + OW'(stamp_idx);
    end
    rd_addr = rd_sum[AW-1:0];
  end

  // Image store: one write port for loads, one registered read port for the search, scan and timestamp.
  always_ff @(posedge clk) begin
    if (load_acc && (write_pointer < PW'(MEM_DEPTH))) begin
      mem[write_pointer[AW-1:0]] <= req.data.data_byte;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fingerprint_time <= '0;
      cutoff_enable    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drs_pkg::CFG_FINGERPRINT: fingerprint_time <= cfg_data;
        drs_pkg::CFG_CUTOFF:      cutoff_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_pointer <= '0;
      image_size    <= '0;
      scan_position <= '0;
      scan_limit    <= '0;
      scan_started  <= 1'b0;
      scan_outcome  <= drs_pkg::ST_RUNNING;
      depth_pend    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // In S_RESULT the output register is reloaded whenever the old transaction leaves.
      if (res.valid && res.ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end

      if (do_advance) begin
        if (scan_position == '0) begin
          scan_outcome <= drs_pkg::ST_NO_MORE;
          pend_res     <= '{status: drs_pkg::ST_NO_MORE, default: '0};
          state        <= S_RESULT;
        end else begin
          scan_position <= scan_position - PW'(1);
          state         <= S_PROBE_HI;
        end
      end else begin
        unique case (state)
          S_IDLE: begin
            if (load_acc) begin
              if (req.data.last) begin
                image_size    <= (write_pointer < PW'(MEM_DEPTH)) ? wp_inc : write_pointer;
                write_pointer <= '0;
                scan_position <= '0;
                scan_limit    <= '0;
                scan_started  <= 1'b0;
                scan_outcome  <= drs_pkg::ST_RUNNING;
              end else if (write_pointer < PW'(MEM_DEPTH)) begin
                write_pointer <= wp_inc;
              end
            end else if (find_acc) begin
              if (scan_outcome != drs_pkg::ST_RUNNING) begin
                pend_res <= '{status: scan_outcome, default: '0};
                state    <= S_RESULT;
              end else begin
                if (!scan_started) begin
                  scan_limit    <= image_size;
                  scan_position <= (image_size >= PW'(drs_pkg::HEADER_LEN)) ?
                                   image_size - PW'(drs_pkg::HEADER_LEN) : '0;
                  scan_started  <= 1'b1;
                end
                state <= S_SEARCH;
              end
            end
          end
          S_PROBE_HI: begin
            state <= S_PROBE_LO;
          end
          S_PROBE_LO: begin
            offset     <= {1'b0, scan_position} + OW'(drs_pkg::HEADER_LEN);
            phase      <= '0;
            shallow    <= '0;
            depth_pend <= 1'b0;
            state      <= S_SCAN;
          end
          S_SCAN: begin
            if (depth_pend) begin
              shallow <= is_shallow ? shallow + 5'd1 : '0;
            end
            if (scan_found) begin
              depth_pend <= 1'b0;
              stamp_idx  <= '0;
              state      <= S_STAMP;
            end else if (scan_stop) begin
              depth_pend   <= 1'b0;
              scan_outcome <= drs_pkg::ST_NO_END;
              pend_res     <= '{status: drs_pkg::ST_NO_END, default: '0};
              state        <= S_RESULT;
            end else begin
              depth_pend <= 1'b1;
              offset     <= offset + ((phase == 3'd0) ? OW'(2) : OW'(1));
              phase      <= (phase == drs_pkg::TEMP_PERIOD - 3'd1) ? 3'd0 : phase + 3'd1;
            end
          end
          S_STAMP: begin
            stamp_idx <= stamp_idx + 3'd1;
            if (stamp_idx != 3'd0) begin
              stamp_lo <= {rdata, stamp_lo[23:8]};
            end
            if (stamp_idx == 3'(drs_pkg::STAMP_BYTES)) begin
              if (cutoff_enable && (stamp <= fingerprint_time)) begin
                scan_outcome <= drs_pkg::ST_NO_MORE;
                pend_res     <= '{status: drs_pkg::ST_NO_MORE, default: '0};
              end else begin
                scan_limit    <= scan_position;
                scan_position <= (scan_position >= PW'(drs_pkg::HEADER_LEN)) ?
                                 scan_position - PW'(drs_pkg::HEADER_LEN) : '0;
                pend_res      <= '{status:      drs_pkg::ST_FOUND,
                                   dive_start:  cur32[14:0],
                                   dive_length: len32[15:0],
                                   dive_time:   stamp};
              end
              state <= S_RESULT;
            end
          end
          S_RESULT: begin
            if (!out_valid || res.ready) begin
              out_data  <= pend_res;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A find keeps the request side closed for at least the following cycle.
  a_find_blocks: assert property (@(posedge clk) disable iff (rst)
    find_acc |=> !req.ready)
    else $error("request accepted right after a find");

  // A terminal outcome holds until the last byte of a new image arrives.
  a_outcome_sticky: assert property (@(posedge clk) disable iff (rst)
    ((scan_outcome != drs_pkg::ST_RUNNING) && !(load_acc && req.data.last))
    |=> (scan_outcome == $past(scan_outcome)))
    else $error("terminal scan outcome changed without a new image");

  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    write_pointer <= PW'(MEM_DEPTH))
    else $error("write pointer beyond store depth");

  // The shallow run stops the scan as soon as it completes.
  a_shallow_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (shallow < drs_pkg::SHALLOW_RUN))
    else $error("shallow run counted past its end");
`endif

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the dive record segmenter with its own predictor of the dive search.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH            = 32768;
  localparam int unsigned CYCLE_LIMIT      = 1_500_000;
  localparam int unsigned IDLE_CYCLES      = 16;
  localparam int unsigned LONG_HOLD_AT     = 30;
  localparam int unsigned LONG_HOLD_CYCLES = 500;
  localparam int unsigned MAX_PRINTS       = 40;
  localparam int unsigned PHASE_ITEMS      = 270;
  localparam int unsigned PHASE_FINDS      = 12;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last;
    logic       typed;
    logic [1:0] want;
  } script_row_t;

  // Opening sequence: empty store, a too-short image, an image whose only dive has no end,
  // a find in the middle of a load, and a short image again.
  localparam script_row_t OPENING [24] = '{
    '{drs_pkg::REQ_FIND, 8'h00, 1'b0, 1'b1, drs_pkg::ST_NO_MORE},
    '{drs_pkg::REQ_LOAD, 8'hFF, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h00, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h80, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h7F, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h01, 1'b1, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_FIND, 8'hFF, 1'b1, 1'b1, drs_pkg::ST_NO_MORE},
    '{drs_pkg::REQ_FIND, 8'h55, 1'b0, 1'b1, drs_pkg::ST_NO_MORE},
    '{drs_pkg::REQ_LOAD, 8'hFF, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h3C, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h00, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'hFF, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'hAA, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h55, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'hFE, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h05, 1'b1, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_FIND, 8'h00, 1'b0, 1'b1, drs_pkg::ST_NO_END},
    '{drs_pkg::REQ_FIND, 8'hC3, 1'b1, 1'b1, drs_pkg::ST_NO_END},
    '{drs_pkg::REQ_LOAD, 8'h12, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h34, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_FIND, 8'h00, 1'b0, 1'b1, drs_pkg::ST_NO_END},
    '{drs_pkg::REQ_LOAD, 8'h56, 1'b0, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_LOAD, 8'h78, 1'b1, 1'b0, drs_pkg::ST_FOUND},
    '{drs_pkg::REQ_FIND, 8'h00, 1'b0, 1'b1, drs_pkg::ST_NO_MORE}
  };

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [drs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [drs_pkg::CFG_DATA_W-1:0] cfg_data;

  drs_req_if req_ch ();
  drs_res_if res_ch ();

  dive_record_segmenter i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the log memory, the backward walk and the configuration.
  logic [7:0]  img_mem [DEPTH];
  int unsigned img_wp = 0;
  int unsigned img_size = 0;
  int unsigned walk_pos = 0;
  int unsigned walk_limit = 0;
  bit          walk_started = 1'b0;
  logic [1:0]  walk_outcome = drs_pkg::ST_RUNNING;
  logic [31:0] fp_time = 32'h0;
  bit          cut_en = 1'b1;

  drs_pkg::res_t dive_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned finds_sent = 0;
  int unsigned dives_seen = 0;
  int unsigned tx_quiet = 0;
  int unsigned rx_quiet = 0;
  int unsigned stall_left = 0;
  bit          long_hold_done = 1'b0;

  function automatic logic [7:0] img_byte(int unsigned addr);
    return (addr < DEPTH) ? img_mem[addr] : 8'h00;
  endfunction

  function automatic void store_byte(logic [7:0] value, logic is_last);
    if (img_wp < DEPTH) begin
      img_mem[img_wp] = value;
      img_wp++;
    end
    if (is_last) begin
      img_size     = img_wp;
      img_wp       = 0;
      walk_pos     = 0;
      walk_limit   = 0;
      walk_started = 1'b0;
      walk_outcome = drs_pkg::ST_RUNNING;
    end
  endfunction

  function automatic drs_pkg::res_t next_dive();
    int unsigned   cur;
    int unsigned   ofs;
    int unsigned   phase;
    int unsigned   shallow;
    bit            found;
    logic [7:0]    depth;
    logic [31:0]   stamp;
    drs_pkg::res_t r;
    r = '0;
    if (walk_outcome != drs_pkg::ST_RUNNING) begin
      r.status = walk_outcome;
      return r;
    end
    if (!walk_started) begin
      walk_limit   = img_size;
      walk_pos     = (img_size >= drs_pkg::HEADER_LEN) ? img_size - drs_pkg::HEADER_LEN : 0;
      walk_started = 1'b1;
    end
    while (walk_pos > 0) begin
      cur      = walk_pos - 1;
      walk_pos = cur;
      if (img_byte(cur) == drs_pkg::START_MARK &&
          img_byte(cur + drs_pkg::MARK_GAP) == drs_pkg::TIME_MARK) begin
        ofs     = cur + drs_pkg::HEADER_LEN;
        phase   = 0;
        shallow = 0;
        found   = 1'b0;
        while (ofs + 1 <= walk_limit) begin
          depth = img_byte(ofs);
          ofs++;
          // The first sample of every group of six carries a temperature byte.
          if (phase == 0) begin
            if (ofs + 1 > walk_limit) break;
            ofs++;
          end
          phase = (phase == drs_pkg::TEMP_PERIOD - 1) ? 0 : phase + 1;
          if (depth < drs_pkg::SHALLOW_DEPTH) begin
            shallow++;
            if (shallow == drs_pkg::SHALLOW_RUN) begin
              found = 1'b1;
              break;
            end
          end else begin
            shallow = 0;
          end
        end
        if (!found) begin
          walk_outcome = drs_pkg::ST_NO_END;
          r.status     = drs_pkg::ST_NO_END;
          return r;
        end
        stamp = {img_byte(cur + drs_pkg::STAMP_OFS + 3), img_byte(cur + drs_pkg::STAMP_OFS + 2),
                 img_byte(cur + drs_pkg::STAMP_OFS + 1), img_byte(cur + drs_pkg::STAMP_OFS)};
        if (cut_en && stamp <= fp_time) begin
          walk_outcome = drs_pkg::ST_NO_MORE;
          r.status     = drs_pkg::ST_NO_MORE;
          return r;
        end
        walk_limit    = cur;
        walk_pos      = (cur >= drs_pkg::HEADER_LEN) ? cur - drs_pkg::HEADER_LEN : 0;
        r.status      = drs_pkg::ST_FOUND;
        r.dive_start  = cur[14:0];
        r.dive_length = 16'(ofs - cur);
        r.dive_time   = stamp;
        return r;
      end
    end
    walk_outcome = drs_pkg::ST_NO_MORE;
    r.status     = drs_pkg::ST_NO_MORE;
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_dive(drs_pkg::res_t got);
    drs_pkg::res_t want;
    dives_seen++;
    if (dive_q.size() == 0) begin
      report($sformatf("result status %0d with no find pending", got.status));
    end else begin
      want = dive_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.dive_start !== want.dive_start)
        report($sformatf("dive_start %0d, expected %0d", got.dive_start, want.dive_start));
      if (got.dive_length !== want.dive_length)
        report($sformatf("dive_length %0d, expected %0d", got.dive_length, want.dive_length));
      if (got.dive_time !== want.dive_time)
        report($sformatf("dive_time %h, expected %h", got.dive_time, want.dive_time));
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (tx_quiet > 0) begin
      tx_quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      tx_quiet = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request and waits for the transaction; the prediction is made on acceptance.
  task automatic send_item(drs_pkg::req_t item, bit typed, drs_pkg::res_t typed_res);
    int unsigned   gap;
    drs_pkg::res_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    if (item.req_type == drs_pkg::REQ_LOAD) begin
      store_byte(item.data_byte, item.last);
    end else begin
      finds_sent++;
      pred = next_dive();
      if (typed && pred != typed_res)
        report($sformatf("predicted status %0d disagrees with table status %0d",
                         pred.status, typed_res.status));
      dive_q.push_back(typed ? typed_res : pred);
    end
  endtask

  task automatic send_load(logic [7:0] value, logic is_last);
    drs_pkg::req_t item;
    item.req_type  = drs_pkg::REQ_LOAD;
    item.data_byte = value;
    item.last      = is_last;
    send_item(item, 1'b0, '0);
  endtask

  task automatic send_find();
    drs_pkg::req_t item;
    item.req_type  = drs_pkg::REQ_FIND;
    item.data_byte = 8'($urandom_range(0, 255));
    item.last      = 1'($urandom_range(0, 1));
    send_item(item, 1'b0, '0);
  endtask

  // One dive record: marker-pair header, then samples ending in a shallow run unless cut short.
  task automatic add_dive(ref logic [7:0] img[$], input logic [31:0] stamp, input bit cut_short);
    int unsigned deep;
    int unsigned total;
    int unsigned s;
    img.push_back(drs_pkg::START_MARK);
    img.push_back(8'($urandom_range(0, 255)));
    img.push_back(stamp[7:0]);
    img.push_back(stamp[15:8]);
    img.push_back(stamp[23:16]);
    img.push_back(stamp[31:24]);
    img.push_back(drs_pkg::TIME_MARK);
    deep  = $urandom_range(0, 12);
    total = deep + drs_pkg::SHALLOW_RUN;
    for (s = 0; s < total; s++) begin
      if (s < deep && $urandom_range(0, 2) != 0)
        img.push_back(8'($urandom_range(drs_pkg::SHALLOW_DEPTH, 255)));
      else
        img.push_back(8'($urandom_range(0, drs_pkg::SHALLOW_DEPTH - 1)));
      if (s % drs_pkg::TEMP_PERIOD == 0) img.push_back(8'($urandom_range(0, 255)));
    end
    if (cut_short) repeat ($urandom_range(1, 8)) void'(img.pop_back());
  endtask

  task automatic build_image(ref logic [7:0] img[$], output int unsigned dives);
    int unsigned kind;
    int unsigned d;
    int unsigned roll;
    logic [31:0] stamp;
    img.delete();
    dives = 0;
    kind  = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 40)) img.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 8)) img.push_back(8'($urandom_range(0, 255)));
      dives = $urandom_range(1, 4);
      stamp = $urandom;
      for (d = 0; d < dives; d++) begin
        roll = $urandom_range(0, 15);
        // Kind 1 leaves the newest dive without its end; kind 2 an older one.
        add_dive(img, (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : stamp,
                 (kind == 1 && d == dives - 1) || (kind == 2 && d == 0 && dives > 1));
        stamp += $urandom_range(1, 1 << 20);
      end
      repeat ($urandom_range(0, 3)) img.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_phase();
    int unsigned item_base;
    int unsigned find_base;
    int unsigned dives;
    int unsigned k;
    logic [7:0]  img[$];
    item_base = items_sent;
    find_base = finds_sent;
    while (items_sent - item_base < PHASE_ITEMS || finds_sent - find_base < PHASE_FINDS) begin
      build_image(img, dives);
      for (k = 0; k < img.size(); k++) begin
        if ($urandom_range(0, 49) == 0) send_find();
        send_load(img[k], k == img.size() - 1);
      end
      repeat (dives + $urandom_range(1, 2)) send_find();
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (dive_q.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] fp, bit cut);
    cfg_we    <= 1'b1;
    cfg_index <= drs_pkg::CFG_FINGERPRINT;
    cfg_data  <= fp;
    fp_time    = fp;
    @(posedge clk);
    cfg_index <= drs_pkg::CFG_CUTOFF;
    cfg_data  <= {31'b0, cut};
    cut_en     = cut;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: checks each transaction and stalls at random, once for a long stretch.
  always @(posedge clk) begin : result_side
    int unsigned roll;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_dive(res_ch.data);
      if (!long_hold_done && dives_seen == LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD_CYCLES;
      end else if (stall_left == 0) begin
        if (rx_quiet > 0) begin
          rx_quiet--;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 2) rx_quiet = $urandom_range(30, 120);
          else if (roll < 20) stall_left = $urandom_range(1, 3);
          else if (roll < 23) stall_left = $urandom_range(8, 40);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned   i;
    int unsigned   phase;
    drs_pkg::req_t item;
    drs_pkg::res_t typed_res;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= drs_pkg::CFG_FINGERPRINT;
    cfg_data     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < 24; i++) begin
      item.req_type    = OPENING[i].req_type;
      item.data_byte   = OPENING[i].data_byte;
      item.last        = OPENING[i].last;
      typed_res        = '0;
      typed_res.status = OPENING[i].want;
      send_item(item, OPENING[i].typed, typed_res);
    end
    run_random_phase();

    for (phase = 1; phase <= 4; phase++) begin
      settle();
      case (phase)
        1: begin
          write_regs(32'hFFFF_FFFF, 1'b1);
        end
        2: begin
          write_regs($urandom, 1'b1);
        end
        3: begin
          write_regs($urandom, 1'b0);
        end
        default: begin
          write_regs(32'h0, 1'b1);
        end
      endcase
      run_random_phase();
    end

    settle();

    if (errors == 0 && dive_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/drs_pkg.sv
hdl/drs_if.sv
hdl/dive_record_segmenter.sv
verif/tb.sv
